/* hdl/ipt_pkg.sv */
// Shared types and constants for the inode policy table.
// Holds the command codes, the stored entry layout and the controller/datapath links.
// No dependencies.
package ipt_pkg;

    localparam int KEY_W       = 64;
    localparam int OPS_W       = 32;
    localparam int BLK_W       = 32;
    localparam int CMD_W       = 2;
    localparam int S_TDATA_W   = 232;
    localparam int M_TDATA_W   = 40;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_LOOKUP = 2'd3
    } cmd_t;

    // One table slot as it is kept in memory.
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] device;
        logic [KEY_W-1:0] inode;
        logic [OPS_W-1:0] mask;
        logic [BLK_W-1:0] blk;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        ST_WIPE,
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic wipe;
        logic commit;
        logic respond;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_end;
        logic wipe_last;
        logic out_busy;
    } dp_status_t;

endpackage

/* hdl/ipt_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Used for the policy slot storage; no dependencies.
module ipt_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/ipt_datapath.sv */
// Datapath of the inode policy table: request registers, slot memory, scan
// tracking and the result register. Depends on ipt_pkg and ipt_ram.
module ipt_datapath #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [ipt_pkg::S_TDATA_W-1:0]    s_tdata,
    input  ipt_pkg::dp_cmd_t                 dp_cmd,
    output ipt_pkg::dp_status_t              dp_status,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ipt_pkg::M_TDATA_W-1:0]    m_tdata
);
    import ipt_pkg::*;

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    cmd_t             cmd_reg;
    logic [KEY_W-1:0] dev_reg;
    logic [KEY_W-1:0] ino_reg;
    logic [OPS_W-1:0] mask_reg;
    logic [BLK_W-1:0] blk_reg;
    logic [OPS_W-1:0] rops_reg;

    logic [CW-1:0]    addr_reg, addr_next;
    logic             rd_vld_reg;
    logic [AW-1:0]    rd_idx_reg;

    logic             hit_reg, free_reg;
    logic [AW-1:0]    hit_idx_reg, free_idx_reg;
    logic [OPS_W-1:0] hit_mask_reg;
    logic [BLK_W-1:0] hit_blk_reg;

    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    logic [ENTRY_W-1:0] rd_data;
    entry_t             rd_entry;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    entry_t             wr_entry;

    logic key_match, track, issue, wipe_last;
    logic found_w, status_w;
    logic [BLK_W-1:0] blk_w;

    ipt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES),
        .ADDR_W(AW)
    ) u_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_entry),
        .rd_addr(addr_reg[AW-1:0]),
        .rd_data(rd_data)
    );

    assign rd_entry  = entry_t'(rd_data);
    assign key_match = rd_entry.valid && (rd_entry.device == dev_reg)
                       && (rd_entry.inode == ino_reg);
    // Read data arrives in the cycle after its address; track it only while scanning.
    assign track     = dp_cmd.scan && rd_vld_reg;
    assign issue     = dp_cmd.scan && (addr_reg < CW'(TABLE_ENTRIES));
    assign wipe_last = (addr_reg == CW'(TABLE_ENTRIES - 1));

    assign dp_status.scan_end  = track && (key_match || rd_idx_reg == AW'(TABLE_ENTRIES - 1));
    assign dp_status.wipe_last = wipe_last;
    assign dp_status.out_busy  = out_valid_reg && !m_tready;

    always_comb begin
        wr_en    = 1'b0;
        wr_addr  = addr_reg[AW-1:0];
        wr_entry = '0;
        if (dp_cmd.wipe) begin
            wr_en = 1'b1;
        end else if (dp_cmd.commit) begin
            case (cmd_reg)
                CMD_ADD: begin
                    wr_entry = '{valid: 1'b1, device: dev_reg, inode: ino_reg,
                                 mask: mask_reg, blk: blk_reg};
                    if (hit_reg) begin
                        wr_en   = 1'b1;
                        wr_addr = hit_idx_reg;
                    end else if (free_reg) begin
                        wr_en   = 1'b1;
                        wr_addr = free_idx_reg;
                    end
                end
                CMD_REMOVE: begin
                    wr_en   = hit_reg;
                    wr_addr = hit_idx_reg;
                end
                default: begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        addr_next = addr_reg;
        if (dp_cmd.load) begin
            addr_next = '0;
        end else if (issue) begin
            addr_next = addr_reg + CW'(1);
        end else if (dp_cmd.wipe) begin
            addr_next = wipe_last ? '0 : addr_reg + CW'(1);
        end
    end

    assign found_w  = (cmd_reg == CMD_LOOKUP) && hit_reg && ((hit_mask_reg & rops_reg) != '0);
    assign blk_w    = found_w ? hit_blk_reg : '0;
    assign status_w = (cmd_reg == CMD_ADD) && !hit_reg && !free_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg      <= '0;
            rd_vld_reg    <= 1'b0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            addr_reg   <= addr_next;
            rd_vld_reg <= issue;
            if (dp_cmd.load) begin
                hit_reg  <= 1'b0;
                free_reg <= 1'b0;
            end else if (track) begin
                if (key_match && !hit_reg) begin
                    hit_reg <= 1'b1;
                end
                if (!rd_entry.valid && !free_reg) begin
                    free_reg <= 1'b1;
                end
            end
            if (dp_cmd.respond) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.load) begin
            cmd_reg  <= cmd_t'(s_tdata[1:0]);
            dev_reg  <= s_tdata[65:2];
            ino_reg  <= s_tdata[129:66];
            mask_reg <= s_tdata[161:130];
            blk_reg  <= s_tdata[193:162];
            rops_reg <= s_tdata[225:194];
        end
        rd_idx_reg <= addr_reg[AW-1:0];
        if (track && key_match && !hit_reg) begin
            hit_idx_reg  <= rd_idx_reg;
            hit_mask_reg <= rd_entry.mask;
            hit_blk_reg  <= rd_entry.blk;
        end
        if (track && !rd_entry.valid && !free_reg) begin
            free_idx_reg <= rd_idx_reg;
        end
        if (dp_cmd.respond) begin
            out_data_reg <= {{(M_TDATA_W - BLK_W - 2){1'b0}}, status_w, blk_w, found_w};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

/* hdl/ipt_ctrl.sv */
// Controller state machine of the inode policy table.
// Sequences wipe, scan, commit and response; depends on ipt_pkg.
module ipt_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  ipt_pkg::cmd_t       s_cmd,
    input  ipt_pkg::dp_status_t dp_status,
    output ipt_pkg::dp_cmd_t    dp_cmd
);
    import ipt_pkg::*;

    state_t state_reg, state_next;
    logic   reply_reg, reply_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_WIPE;
            reply_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            reply_reg <= reply_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        reply_next = reply_reg;
        s_tready   = 1'b0;
        dp_cmd     = '0;
        case (state_reg)
            ST_WIPE: begin
                dp_cmd.wipe = 1'b1;
                if (dp_status.wipe_last) begin
                    // A clear request answers once the sweep is done; the reset sweep does not.
                    state_next = reply_reg ? ST_RESP : ST_IDLE;
                    reply_next = 1'b0;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    dp_cmd.load = 1'b1;
                    if (s_cmd == CMD_CLEAR) begin
                        state_next = ST_WIPE;
                        reply_next = 1'b1;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                dp_cmd.scan = 1'b1;
                if (dp_status.scan_end) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                dp_cmd.commit = 1'b1;
                state_next    = ST_RESP;
            end
            ST_RESP: begin
                if (!dp_status.out_busy) begin
                    dp_cmd.respond = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* hdl/inode_policy_table_core.sv */
// Top level of the inode policy table: controller plus datapath.
// Depends on ipt_pkg, ipt_ctrl, ipt_datapath and ipt_ram.
//
//  Channel | Direction | Carries
//  s_      | in        | one request: command, key, masks, block value
//  m_      | out       | one result per request: found, block value, status
//
// Add, remove and lookup scan the slot memory one entry per cycle through its
// single read port, stopping at a key match.
// Clear sweeps the memory one entry per cycle.
// After reset the same sweep runs before s_tready rises.
// A waiting result does not block the next request until its own result is due.
module inode_policy_table_core #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // cmd[1:0], device_number[65:2], inode_number[129:66], allowed_ops[161:130],
    // block_setting[193:162], requested_ops[225:194], zero fill above
    input  logic [ipt_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // found[0], block_result[32:1], status[33], zero fill above
    output logic [ipt_pkg::M_TDATA_W-1:0] m_tdata
);
    import ipt_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    ipt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_cmd    (cmd_t'(s_tdata[1:0])),
        .dp_status(dp_status),
        .dp_cmd   (dp_cmd)
    );

    ipt_datapath #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .dp_cmd   (dp_cmd),
        .dp_status(dp_status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef SYNTH
    // The slot memory is swept after reset before any request is taken.
    a_reset_sweep: assert property (@(posedge aclk) !aresetn |=> !s_tready)
        else $error("request accepted during the reset sweep");

    // One request at a time: a new request is never taken right after one.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another is in progress");

    // Scanning and sweeping share the address counter and never overlap.
    a_scan_wipe_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(dp_cmd.scan && dp_cmd.wipe))
        else $error("scan and sweep active together");

    // A result is loaded only while the output register is free.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.respond |-> !(m_tvalid && !m_tready))
        else $error("result overwrote a pending result");
`endif

endmodule

/* tb/inode_policy_table_core_tb.sv */
// Self-checking testbench for inode_policy_table_core: streams add, remove, clear and lookup
// requests, predicts every result from its own copy of the policy table and checks them.
// Depends on ipt_pkg and the inode_policy_table_core RTL.
module inode_policy_table_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ipt_pkg::*;

    localparam int SLOTS       = 64;
    localparam int N_ITEMS     = 1650;
    localparam int POOL_N      = 96;
    localparam int N_DEVS      = 6;
    localparam int REQ_BITS    = CMD_W + 2 * KEY_W + 2 * OPS_W + BLK_W;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        cmd_t             op;
        logic [KEY_W-1:0] dev;
        logic [KEY_W-1:0] ino;
        logic [OPS_W-1:0] allow;
        logic [BLK_W-1:0] blk;
        logic [OPS_W-1:0] req_ops;
    } policy_req_t;

    typedef struct packed {
        logic             found;
        logic [BLK_W-1:0] blk;
        logic             full;
    } verdict_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    inode_policy_table_core #(
        .TABLE_ENTRIES(SLOTS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #1 aclk = ~aclk;

    policy_req_t pend_q[$];
    verdict_t    verdict_q[$];

    // Expected contents of the policy table.
    logic             tbl_used[SLOTS];
    logic [KEY_W-1:0] tbl_dev[SLOTS];
    logic [KEY_W-1:0] tbl_ino[SLOTS];
    logic [OPS_W-1:0] tbl_mask[SLOTS];
    logic [BLK_W-1:0] tbl_blk[SLOTS];

    logic [KEY_W-1:0] pool_dev[POOL_N];
    logic [KEY_W-1:0] pool_ino[POOL_N];

    int  item_total   = N_ITEMS;
    int  n_in         = 0;
    int  n_out        = 0;
    int  n_bad        = 0;
    int  quiet_cycles = 0;
    int  hold_left    = 0;
    bit  hold_done    = 1'b0;

    function automatic verdict_t policy_predict(policy_req_t r);
        verdict_t v;
        int       hit;
        int       spare;
        int       i;
        v     = '0;
        hit   = -1;
        spare = -1;
        // Walk downward so that spare ends on the lowest free slot.
        for (i = SLOTS - 1; i >= 0; i--) begin
            if (tbl_used[i] && tbl_dev[i] == r.dev && tbl_ino[i] == r.ino)
                hit = i;
            if (!tbl_used[i])
                spare = i;
        end
        case (r.op)
            CMD_ADD: begin
                if (hit < 0 && spare >= 0) begin
                    hit           = spare;
                    tbl_used[hit] = 1'b1;
                    tbl_dev[hit]  = r.dev;
                    tbl_ino[hit]  = r.ino;
                end
                if (hit >= 0) begin
                    tbl_mask[hit] = r.allow;
                    tbl_blk[hit]  = r.blk;
                end else begin
                    v.full = 1'b1;
                end
            end
            CMD_REMOVE: begin
                if (hit >= 0)
                    tbl_used[hit] = 1'b0;
            end
            CMD_CLEAR: begin
                for (i = 0; i < SLOTS; i++)
                    tbl_used[i] = 1'b0;
            end
            default: begin
                if (hit >= 0 && (tbl_mask[hit] & r.req_ops) != '0) begin
                    v.found = 1'b1;
                    v.blk   = tbl_blk[hit];
                end
            end
        endcase
        return v;
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_req(policy_req_t r);
        return {{(S_TDATA_W - REQ_BITS){1'b0}}, r.req_ops, r.blk, r.allow, r.ino, r.dev, r.op};
    endfunction

    function automatic logic [OPS_W-1:0] pick_ops();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return 32'd1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    task automatic pick_key(output logic [KEY_W-1:0] dev, output logic [KEY_W-1:0] ino);
        int k;
        if ($urandom_range(0, 99) < 85) begin
            k   = $urandom_range(0, POOL_N - 1);
            dev = pool_dev[k];
            ino = pool_ino[k];
        end else begin
            dev = {$urandom, $urandom};
            ino = {$urandom, $urandom};
        end
    endtask

    task automatic queue_req(cmd_t op, logic [KEY_W-1:0] dev, logic [KEY_W-1:0] ino,
                             logic [OPS_W-1:0] allow, logic [BLK_W-1:0] blk,
                             logic [OPS_W-1:0] req_ops);
        policy_req_t r;
        r.op      = op;
        r.dev     = dev;
        r.ino     = ino;
        r.allow   = allow;
        r.blk     = blk;
        r.req_ops = req_ops;
        pend_q.push_back(r);
    endtask

    task automatic queue_random();
        logic [KEY_W-1:0] dev;
        logic [KEY_W-1:0] ino;
        int               roll;
        cmd_t             op;
        roll = $urandom_range(0, 99);
        if (roll < 35)
            op = CMD_ADD;
        else if (roll < 55)
            op = CMD_REMOVE;
        else if (roll < 57)
            op = CMD_CLEAR;
        else
            op = CMD_LOOKUP;
        pick_key(dev, ino);
        queue_req(op, dev, ino, pick_ops(), pick_ops(), pick_ops());
    endtask

    // Clear, then add distinct keys past capacity, then poke at the full table.
    task automatic queue_fill();
        logic [KEY_W-1:0] base_dev;
        logic [KEY_W-1:0] base_ino;
        int               k;
        int               extra;
        base_dev = {$urandom, $urandom};
        base_ino = {$urandom, 32'd0};
        extra    = $urandom_range(1, 4);
        queue_req(CMD_CLEAR, base_dev, base_ino, pick_ops(), pick_ops(), pick_ops());
        for (k = 0; k < SLOTS + extra; k++)
            queue_req(CMD_ADD, base_dev, base_ino + KEY_W'(k), pick_ops(), pick_ops(),
                      pick_ops());
        k = $urandom_range(0, SLOTS - 1);
        queue_req(CMD_LOOKUP, base_dev, base_ino + KEY_W'(k), pick_ops(), pick_ops(), '1);
        queue_req(CMD_REMOVE, base_dev, base_ino + KEY_W'(k), pick_ops(), pick_ops(),
                  pick_ops());
        queue_req(CMD_ADD, base_dev, base_ino + KEY_W'(SLOTS + 10), '1, $urandom, pick_ops());
        queue_req(CMD_ADD, base_dev, base_ino + KEY_W'(SLOTS + 11), '1, $urandom, pick_ops());
        queue_req(CMD_ADD, base_dev, base_ino + KEY_W'(k ^ 1), '1, $urandom, pick_ops());
        queue_req(CMD_LOOKUP, base_dev, base_ino + KEY_W'(SLOTS + 10), pick_ops(), pick_ops(),
                  '1);
    endtask

    function automatic int sender_idle_pct();
        if (n_in < item_total / 3)
            return 19;
        else if (n_in < 2 * item_total / 3)
            return 81;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (n_in < item_total / 3)
            return 81;
        else if (n_in < 2 * item_total / 3)
            return 19;
        return 0;
    endfunction

    task automatic flag_mismatch(string field, logic [BLK_W-1:0] want, logic [BLK_W-1:0] got);
        n_bad++;
        if (n_bad <= MAX_REPORTS)
            $display("result %0d, %s: expected %h, got %h", n_out, field, want, got);
    endtask

    // Request driver: the head of pend_q is on the bus while s_tvalid is high.
    always @(posedge aclk) begin
        logic offer;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                verdict_q.push_back(policy_predict(pend_q.pop_front()));
                n_in <= n_in + 1;
            end
            if (!s_tvalid || s_tready) begin
                offer = pend_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct();
                s_tvalid <= offer;
                if (offer)
                    s_tdata <= pack_req(pend_q[0]);
            end
        end
    end

    // Result monitor and receiver back-pressure.
    always @(posedge aclk) begin
        verdict_t got;
        verdict_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.found = m_tdata[0];
                got.blk   = m_tdata[32:1];
                got.full  = m_tdata[33];
                n_out <= n_out + 1;
                if (verdict_q.size() == 0) begin
                    flag_mismatch("result with no request outstanding", '0, m_tdata[32:1]);
                end else begin
                    want = verdict_q.pop_front();
                    if (got.found !== want.found)
                        flag_mismatch("found", BLK_W'(want.found), BLK_W'(got.found));
                    if (got.blk !== want.blk)
                        flag_mismatch("block_result", want.blk, got.blk);
                    if (got.full !== want.full)
                        flag_mismatch("status", BLK_W'(want.full), BLK_W'(got.full));
                end
            end
            // One long hold-off late in the run lets the block back up its input.
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else if (!hold_done && n_in >= item_total * 5 / 6) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                m_tready  <= 1'b0;
            end else begin
                m_tready <= $urandom_range(0, 99) >= receiver_idle_pct();
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        logic [KEY_W-1:0] shared_dev[N_DEVS];
        logic [KEY_W-1:0] dev;
        logic [KEY_W-1:0] ino;
        int               k;
        int               next_fill;

        for (k = 0; k < SLOTS; k++)
            tbl_used[k] = 1'b0;

        // Keys share a few device numbers so that half-matching keys are common.
        shared_dev[0] = '0;
        shared_dev[1] = '1;
        for (k = 2; k < N_DEVS; k++)
            shared_dev[k] = {$urandom, $urandom};
        for (k = 0; k < POOL_N; k++) begin
            pool_dev[k] = shared_dev[k % N_DEVS];
            pool_ino[k] = {$urandom, $urandom};
        end
        pool_ino[0]      = '0;
        pool_ino[1]      = '1;
        pool_ino[N_DEVS] = '1;

        dev = {$urandom, $urandom};
        ino = {$urandom, $urandom};
        queue_req(CMD_LOOKUP, '0, '0, '1, '1, '1);
        queue_req(CMD_REMOVE, '1, '1, '1, '1, '1);
        queue_req(CMD_ADD, '0, '0, '1, '1, '0);
        queue_req(CMD_ADD, '1, '1, 32'h1, '0, '1);
        queue_req(CMD_LOOKUP, '0, '0, '0, '0, 32'h8000_0000);
        queue_req(CMD_LOOKUP, '1, '1, '1, '1, 32'hFFFF_FFFE);
        queue_req(CMD_LOOKUP, '1, '1, '0, '0, 32'h1);
        queue_req(CMD_ADD, '0, '0, '0, 32'h5, '1);
        queue_req(CMD_LOOKUP, '0, '0, '1, '1, '1);
        queue_req(CMD_ADD, '0, '0, 32'h0000_8001, 32'hDEAD_BEEF, '0);
        queue_req(CMD_LOOKUP, '0, '0, '0, '0, 32'h0000_8000);
        queue_req(CMD_LOOKUP, '0, '1, '1, '1, '1);
        queue_req(CMD_LOOKUP, '1, '0, '1, '1, '1);
        queue_req(CMD_REMOVE, '0, '0, '0, '0, '0);
        queue_req(CMD_LOOKUP, '0, '0, '1, '1, '1);
        queue_req(CMD_REMOVE, '0, '0, '1, '1, '1);
        queue_req(CMD_ADD, dev, ino, $urandom, $urandom, $urandom);
        queue_req(CMD_ADD, '0, '1, '1, '1, '1);
        queue_req(CMD_CLEAR, '1, '1, '1, '1, '1);
        queue_req(CMD_LOOKUP, '1, '1, '1, '1, '1);
        queue_req(CMD_LOOKUP, dev, ino, '1, '1, '1);
        queue_req(CMD_ADD, dev, ino, '1, 32'h7, '0);
        queue_req(CMD_LOOKUP, dev, ino, '0, '0, '1);
        queue_req(CMD_CLEAR, '0, '0, '0, '0, '0);

        next_fill = pend_q.size() + $urandom_range(50, 300);
        while (pend_q.size() < N_ITEMS) begin
            if (pend_q.size() >= next_fill) begin
                queue_fill();
                next_fill = pend_q.size() + $urandom_range(300, 600);
            end else begin
                queue_random();
            end
        end
        item_total = pend_q.size();

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (pend_q.size() != 0 || verdict_q.size() != 0)
            @(posedge aclk);
        repeat (SLOTS + 8) @(posedge aclk);

        if (n_bad == 0 && verdict_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* files.f */
hdl/ipt_pkg.sv
hdl/ipt_ram.sv
hdl/ipt_datapath.sv
hdl/ipt_ctrl.sv
hdl/inode_policy_table_core.sv
tb/inode_policy_table_core_tb.sv
